// ===== sv/der_sequence_splitter_top_defines.svh =====
// Assertion macros for the DER sequence splitter RTL.
`ifndef DER_SEQUENCE_SPLITTER_TOP_DEFINES_SVH
`define DER_SEQUENCE_SPLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked at every edge outside reset.
`define DSS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dss invariant violated");
// Same-cycle implication.
`define DSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dss implication violated");
// Next-cycle implication.
`define DSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dss next-cycle check violated");
`else
`define DSS_ASSERT(lbl, cond)
`define DSS_ASSERT_IMPL(lbl, ante, cons)
`define DSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/dss_pkg.sv =====
// Types and constants for the DER sequence splitter.
package dss_pkg;

  localparam int unsigned MAX_LEN_BYTES = 4;
  localparam int unsigned LBL_W         = $clog2(MAX_LEN_BYTES + 1);

  localparam logic [7:0] OUTER_TAG_RESET = 8'h30;

  typedef enum logic [2:0] {
    PH_OTAG      = 3'd0,
    PH_LEN_FIRST = 3'd1,
    PH_LEN_MORE  = 3'd2,
    PH_ITAG      = 3'd3,
    PH_CONTENT   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_OUTER_TAG = 3'd0,
    ROLE_OUTER_LEN = 3'd1,
    ROLE_ITEM_TAG  = 3'd2,
    ROLE_ITEM_LEN  = 3'd3,
    ROLE_CONTENT   = 3'd4,
    ROLE_IGNORED   = 3'd5
  } role_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TAG      = 2'd1,
    ERR_LEN_LONG = 2'd2,
    ERR_OVERRUN  = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0]  byte_echo;
    role_t       byte_role;
    logic [15:0] item_number;
    logic        item_start;
    logic        item_end;
    logic [31:0] item_length;
    logic        length_done;
    logic        sequence_end;
    err_t        error_code;
  } res_t;

endpackage

// ===== sv/dss_parser.sv =====
// Parse state and per-byte decode of the DER sequence splitter.
`include "der_sequence_splitter_top_defines.svh"

module dss_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  input  logic [7:0]        outer_tag,
  output dss_pkg::res_t     res
);

  dss_pkg::phase_t            phase_r, phase_nxt;
  logic [31:0]                outer_rem_r, outer_rem_nxt;
  logic [31:0]                item_rem_r, item_rem_nxt;
  logic [dss_pkg::LBL_W-1:0]  lbl_r, lbl_nxt;
  logic [31:0]                acc_r, acc_nxt;
  logic [15:0]                cnt_r, cnt_nxt;
  logic                       in_outer_r, in_outer_nxt;

  // shared decode
  logic                       is_tag, tag_match, len_phase, uses_orem;
  logic [31:0]                orem_use, acc_shift, cmp_len, item_rem_dec;
  logic                       lf_long, lf_n_zero, lf_complete, lf_too_many, lf_start_more;
  logic [dss_pkg::LBL_W-1:0]  lm_lbl;
  logic                       complete, cmp_over, cmp_zero, content_end;
  logic                       item_end_ev, seq_end_ev, err_overrun;

  always_comb begin
    is_tag       = restart || (phase_r == dss_pkg::PH_OTAG);
    tag_match    = (data_byte == outer_tag);
    len_phase    = (phase_r == dss_pkg::PH_LEN_FIRST) || (phase_r == dss_pkg::PH_LEN_MORE);
    uses_orem    = (phase_r == dss_pkg::PH_ITAG) || (phase_r == dss_pkg::PH_CONTENT) ||
                   (len_phase && !in_outer_r);
    orem_use     = uses_orem ? outer_rem_r - 32'd1 : outer_rem_r;
    acc_shift    = {acc_r[23:0], data_byte};
    item_rem_dec = item_rem_r - 32'd1;

    lf_long       = data_byte[7];
    lf_n_zero     = (data_byte[6:0] == 7'd0);
    lf_complete   = !lf_long || lf_n_zero;
    lf_too_many   = lf_long && !lf_n_zero && (data_byte[6:0] > 7'(dss_pkg::MAX_LEN_BYTES));
    lm_lbl        = (lbl_r != '0) ? lbl_r - dss_pkg::LBL_W'(1) : '0;

    cmp_len  = (phase_r == dss_pkg::PH_LEN_MORE) ? acc_shift :
               (lf_long ? 32'd0 : {24'd0, data_byte});
    complete = !is_tag &&
               (((phase_r == dss_pkg::PH_LEN_FIRST) && lf_complete) ||
                ((phase_r == dss_pkg::PH_LEN_MORE) && (lm_lbl == '0)));
    cmp_over = (cmp_len > orem_use);
    cmp_zero = (cmp_len == 32'd0);

    // a long-form count that is accepted and opens the extra length bytes
    lf_start_more = !is_tag && (phase_r == dss_pkg::PH_LEN_FIRST) && !lf_complete &&
                    !lf_too_many && (in_outer_r || orem_use != 32'd0);

    content_end = !is_tag && (phase_r == dss_pkg::PH_CONTENT) && (item_rem_dec == 32'd0);
    item_end_ev = (complete && !in_outer_r && !cmp_over && cmp_zero) || content_end;
    seq_end_ev  = (item_end_ev && orem_use == 32'd0) || (complete && in_outer_r && cmp_zero);

    err_overrun = !is_tag &&
                  (((phase_r == dss_pkg::PH_ITAG) && orem_use == 32'd0) ||
                   (complete && !in_outer_r && cmp_over) ||
                   ((phase_r == dss_pkg::PH_LEN_FIRST) && lf_long && !lf_n_zero &&
                    !lf_too_many && !in_outer_r && orem_use == 32'd0) ||
                   ((phase_r == dss_pkg::PH_LEN_MORE) && !complete && !in_outer_r &&
                    orem_use == 32'd0));
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    outer_rem_nxt = outer_rem_r;
    item_rem_nxt  = item_rem_r;
    lbl_nxt       = lbl_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    in_outer_nxt  = in_outer_r;
    if (is_tag) begin
      cnt_nxt = 16'd0;
      if (tag_match) begin
        in_outer_nxt = 1'b1;
        phase_nxt    = dss_pkg::PH_LEN_FIRST;
      end else begin
        phase_nxt = dss_pkg::PH_OTAG;
      end
    end else begin
      outer_rem_nxt = orem_use;
      unique case (phase_r)
        dss_pkg::PH_ITAG: begin
          if (orem_use == 32'd0) begin
            phase_nxt = dss_pkg::PH_OTAG;
          end else begin
            in_outer_nxt = 1'b0;
            phase_nxt    = dss_pkg::PH_LEN_FIRST;
          end
        end
        dss_pkg::PH_LEN_FIRST, dss_pkg::PH_LEN_MORE: begin
          if (phase_r == dss_pkg::PH_LEN_MORE) begin
            acc_nxt = acc_shift;
            lbl_nxt = lm_lbl;
          end
          if (lf_start_more) begin
            lbl_nxt   = dss_pkg::LBL_W'(data_byte[6:0]);
            acc_nxt   = 32'd0;
            phase_nxt = dss_pkg::PH_LEN_MORE;
          end else if (complete && in_outer_r) begin
            outer_rem_nxt = cmp_len;
            phase_nxt     = cmp_zero ? dss_pkg::PH_OTAG : dss_pkg::PH_ITAG;
          end else if (complete && !cmp_over && !cmp_zero) begin
            item_rem_nxt = cmp_len;
            phase_nxt    = dss_pkg::PH_CONTENT;
          end else if (err_overrun ||
                       ((phase_r == dss_pkg::PH_LEN_FIRST) && lf_too_many)) begin
            phase_nxt = dss_pkg::PH_OTAG;
          end
        end
        dss_pkg::PH_CONTENT: begin
          item_rem_nxt = item_rem_dec;
        end
        default: begin
          phase_nxt = dss_pkg::PH_OTAG;
        end
      endcase
      if (item_end_ev) begin
        if (orem_use == 32'd0) begin
          phase_nxt = dss_pkg::PH_OTAG;
        end else begin
          phase_nxt = dss_pkg::PH_ITAG;
          if (cnt_r != 16'hFFFF) begin
            cnt_nxt = cnt_r + 16'd1;
          end
        end
      end
    end
  end

  // result of this byte
  always_comb begin
    res              = '0;
    res.byte_echo    = data_byte;
    res.item_number  = cnt_nxt;
    res.byte_role    = dss_pkg::ROLE_IGNORED;
    res.error_code   = dss_pkg::ERR_NONE;
    res.item_start   = 1'b0;
    res.item_end     = item_end_ev;
    res.length_done  = complete;
    res.item_length  = complete ? cmp_len : 32'd0;
    res.sequence_end = seq_end_ev;
    if (is_tag) begin
      if (tag_match) begin
        res.byte_role = dss_pkg::ROLE_OUTER_TAG;
      end else begin
        res.error_code = dss_pkg::ERR_TAG;
      end
    end else begin
      unique case (phase_r)
        dss_pkg::PH_ITAG: begin
          res.byte_role  = dss_pkg::ROLE_ITEM_TAG;
          res.item_start = 1'b1;
        end
        dss_pkg::PH_LEN_FIRST, dss_pkg::PH_LEN_MORE: begin
          res.byte_role = in_outer_r ? dss_pkg::ROLE_OUTER_LEN : dss_pkg::ROLE_ITEM_LEN;
        end
        dss_pkg::PH_CONTENT: begin
          res.byte_role = dss_pkg::ROLE_CONTENT;
        end
        default: begin
          res.byte_role = dss_pkg::ROLE_IGNORED;
        end
      endcase
      if (phase_r == dss_pkg::PH_LEN_FIRST && lf_too_many) begin
        res.error_code = dss_pkg::ERR_LEN_LONG;
      end else if (err_overrun) begin
        res.error_code = dss_pkg::ERR_OVERRUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dss_pkg::PH_OTAG;
      outer_rem_r <= '0;
      item_rem_r  <= '0;
      lbl_r       <= '0;
      acc_r       <= '0;
      cnt_r       <= '0;
      in_outer_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      outer_rem_r <= outer_rem_nxt;
      item_rem_r  <= item_rem_nxt;
      lbl_r       <= lbl_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      in_outer_r  <= in_outer_nxt;
    end
  end

  `DSS_ASSERT_NEXT(a_tag_clears_count, in_fire && is_tag, cnt_r == 16'd0)
  `DSS_ASSERT_IMPL(a_content_bounds, phase_r == dss_pkg::PH_CONTENT,
                   item_rem_r != 32'd0 && item_rem_r <= outer_rem_r)
  `DSS_ASSERT_IMPL(a_item_tag_room, phase_r == dss_pkg::PH_ITAG, outer_rem_r != 32'd0)
  `DSS_ASSERT_IMPL(a_len_more_count, phase_r == dss_pkg::PH_LEN_MORE,
                   lbl_r != '0 && lbl_r <= dss_pkg::LBL_W'(dss_pkg::MAX_LEN_BYTES))

endmodule

// ===== sv/der_sequence_splitter_top.sv =====
// Top level of the DER sequence splitter: handshakes, tag register, result register.
//
// Usage: bytes of a DER SEQUENCE enter on the in_ stream, one request per byte;
// in_tuser[0] set forces that byte to be read as a new outer tag. Each accepted
// byte gives exactly one request on the out_ stream carrying the byte, its role
// (out_tuser), item number, start/end marks, decoded length and error code;
// out_tlast marks the last byte of the whole sequence.
// out_tvalid rises the cycle after acceptance; throughput is one byte per cycle while
// out_tready is high, set by the single decode stage between the parse state and the
// result register. in_tready is high while the result register is empty or being taken,
// so a stalled receiver holds the result in place and stops input after one byte.
// The cfg_ port writes the expected outer tag (0x30 after reset); write it only
// while no byte is in flight. Synchronous active-low reset returns the parser to
// expecting an outer tag, clears all counters and empties the result register.
module der_sequence_splitter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] byte_echo, [23:8] item_number, [24] item_start,
                                  // [25] item_end, [57:26] item_length, [58] length_done,
                                  // [60:59] error_code, [63:61] zero
  output logic [2:0]  out_tuser,  // [2:0] byte_role
  output logic        out_tlast,  // sequence_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic          in_fire;
  logic [7:0]    outer_tag_r;
  logic          out_valid_r;
  dss_pkg::res_t out_res_r;
  dss_pkg::res_t step_res;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_tag_r <= dss_pkg::OUTER_TAG_RESET;
    end else if (cfg_valid) begin
      outer_tag_r <= cfg_data;
    end
  end

  dss_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_tdata),
    .restart   (in_tuser[0]),
    .outer_tag (outer_tag_r),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0,
                       out_res_r.error_code,
                       out_res_r.length_done,
                       out_res_r.item_length,
                       out_res_r.item_end,
                       out_res_r.item_start,
                       out_res_r.item_number,
                       out_res_r.byte_echo};
  assign out_tuser  = out_res_r.byte_role;
  assign out_tlast  = out_res_r.sequence_end;

endmodule
